// ===== rtl/lr_pkg.sv =====
// Shared types, codes and constants of the line rasterizer.
package lr_pkg;

    // Default geometry
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ALPHA_BITS     = 8;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    // Input word opcodes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Line modes
    localparam logic MODE_ALIASED = 1'b0;
    localparam logic MODE_WU      = 1'b1;

    // Register select (word address bit of paddr)
    localparam logic REG_LINE_MODE    = 1'b0;
    localparam logic REG_STROKE_ALPHA = 1'b1;

    // Line walk phases
    localparam logic [1:0] PH_WU_FIRST = 2'd0;
    localparam logic [1:0] PH_WU_LAST  = 2'd1;
    localparam logic [1:0] PH_WU_MID   = 2'd2;
    localparam logic [1:0] PH_BRES     = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch a new line from the input word
        logic adv;        // produce the next pixel word(s)
        logic div_step;   // one gradient divider iteration
        logic div_first;  // first divider iteration (no remainder shift)
        logic div_fin;    // form slope and minor accumulator
        logic sel;        // result slot shown on the output
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       busy;
        logic [1:0] n_res;  // words that an advance would produce now
    } t_sts;

endpackage

// ===== rtl/lr_ctrl.sv =====
// Controller: handshakes, divider sequencing and result word count.
module lr_ctrl
    import lr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_opcode,
    input  logic i_line_mode,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_pend, n_pend;
    logic                r_head, n_head;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_out_fire;
    logic                w_in_fire;

    assign o_out_valid = (r_pend != 2'd0);
    assign w_out_fire  = o_out_valid & i_out_ready;
    // take a new word once the last pending result leaves
    assign o_in_ready  = (r_state == ST_IDLE) &&
                         ((r_pend == 2'd0) || ((r_pend == 2'd1) && w_out_fire));
    assign w_in_fire   = i_in_valid & o_in_ready;

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        n_pend          = r_pend;
        n_head          = r_head;
        n_cnt           = r_cnt;
        o_cmd           = '0;
        o_cmd.sel       = r_head;
        o_cmd.load      = w_in_fire && (i_opcode == OP_START);
        o_cmd.adv       = w_in_fire && (i_opcode == OP_ADVANCE);

        if (w_in_fire) begin
            n_head = 1'b0;
            n_pend = (i_opcode == OP_ADVANCE) ? i_sts.n_res : 2'd0;
        end else if (w_out_fire) begin
            n_head = 1'b1;
            n_pend = r_pend - 2'd1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load && (i_line_mode == MODE_WU)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 2'd0;
            r_head  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/lr_datapath.sv =====
// Datapath: line setup, gradient divider, Bresenham and Wu steppers, result slots.
module lr_datapath
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic                         i_line_mode,
    input  logic [ALPHA_BITS-1:0]        i_stroke_alpha,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output t_sts                         o_sts,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [ALPHA_BITS-1:0]        o_pixel_alpha,
    output logic                         o_last_pixel
);

    localparam int CB = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int AB = ALPHA_BITS;
    localparam int AW = CB + FB;

    // Line state
    logic               r_busy, n_busy;
    logic [1:0]         r_phase, n_phase;
    logic               r_steep, n_steep;
    logic signed [CB:0] r_cur_major, n_cur_major;
    logic signed [CB-1:0] r_stop_major, n_stop_major;
    logic signed [CB-1:0] r_cur_minor, n_cur_minor;
    logic signed [CB-1:0] r_stop_minor, n_stop_minor;
    logic [AW-1:0]      r_accum, n_accum;
    logic [FB+1:0]      r_slope, n_slope;
    logic signed [CB+2:0] r_err, n_err;
    logic [CB:0]        r_adx, n_adx;
    logic signed [CB+1:0] r_nady, n_nady;
    logic [1:0]         r_signs, n_signs;
    // Divider
    logic [CB-1:0]      r_div_d, n_div_d;
    logic [CB-1:0]      r_rem, n_rem;
    logic [FB:0]        r_quo, n_quo;
    logic               r_ddy_neg, n_ddy_neg;
    // Result slots
    logic signed [CB-1:0] r_px [2];
    logic signed [CB-1:0] r_py [2];
    logic [AB-1:0]        r_pa [2];
    logic                 r_pl [2];

    // Setup terms
    logic signed [CB:0] w_ax, w_ay;
    logic [CB:0]        w_abs_ax, w_abs_ay;
    logic               w_st, w_ord;
    logic signed [CB-1:0] w_a0, w_b0, w_a1, w_b1, w_s0, w_t0, w_s1, w_t1;
    logic signed [CB:0] w_wdx, w_wdy;
    logic [CB:0]        w_wdy_abs;
    // Divider terms
    logic [CB:0]        w_dt, w_dsub;
    logic               w_dge;
    logic [FB:0]        w_mag;
    logic [FB+1:0]      w_slope;
    // Wu terms
    logic [FB-1:0]      w_frac;
    logic signed [CB-1:0] w_whole;
    logic [FB:0]        w_cov_hi;
    logic [AB+FB:0]     w_prod_hi;
    logic [AB+FB-1:0]   w_prod_lo;
    logic signed [CB:0] w_stop_ext, w_cur_inc;
    // Bresenham terms
    logic signed [CB+3:0] w_e2;
    logic               w_maj_eq, w_min_eq, w_at_end, w_c1, w_c2, w_upd1, w_upd2, w_done;
    logic signed [CB+2:0] w_add1, w_add2;
    // Slot contents before axis mapping
    logic signed [CB-1:0] w_maj [2];
    logic signed [CB-1:0] w_min [2];
    logic [AB-1:0]        w_alp [2];
    logic                 w_lst [2];
    logic                 w_map_steep;

    // Status
    assign o_sts.busy  = r_busy;
    assign o_sts.n_res = !r_busy ? 2'd0 : ((r_phase == PH_BRES) ? 2'd1 : 2'd2);

    // Output slot select
    assign o_pixel_x     = r_px[i_cmd.sel];
    assign o_pixel_y     = r_py[i_cmd.sel];
    assign o_pixel_alpha = r_pa[i_cmd.sel];
    assign o_last_pixel  = r_pl[i_cmd.sel];

    // Endpoint deltas, steepness and x-major ordering
    assign w_ax     = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
    assign w_ay     = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
    assign w_abs_ax = w_ax[CB] ? (~w_ax + 1'b1) : w_ax;
    assign w_abs_ay = w_ay[CB] ? (~w_ay + 1'b1) : w_ay;
    assign w_st     = w_abs_ay > w_abs_ax;
    assign w_a0     = w_st ? i_start_y : i_start_x;
    assign w_b0     = w_st ? i_start_x : i_start_y;
    assign w_a1     = w_st ? i_end_y : i_end_x;
    assign w_b1     = w_st ? i_end_x : i_end_y;
    assign w_ord    = w_a0 > w_a1;
    assign w_s0     = w_ord ? w_a1 : w_a0;
    assign w_t0     = w_ord ? w_b1 : w_b0;
    assign w_s1     = w_ord ? w_a0 : w_a1;
    assign w_t1     = w_ord ? w_b0 : w_b1;
    assign w_wdx    = {w_s1[CB-1], w_s1} - {w_s0[CB-1], w_s0};
    assign w_wdy    = {w_t1[CB-1], w_t1} - {w_t0[CB-1], w_t0};
    assign w_wdy_abs = w_wdy[CB] ? (~w_wdy + 1'b1) : w_wdy;

    // One restoring divide iteration; the remainder stays below the divisor
    assign w_dt   = i_cmd.div_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_dge  = w_dt >= {1'b0, r_div_d};
    assign w_dsub = w_dt - {1'b0, r_div_d};

    // Signed slope; a single-point line takes gradient one
    assign w_mag   = (r_div_d == '0) ? {1'b1, {FB{1'b0}}} : r_quo;
    assign w_slope = r_ddy_neg ? (~{1'b0, w_mag} + 1'b1) : {1'b0, w_mag};

    // Interior column coverage
    assign w_frac    = r_accum[FB-1:0];
    assign w_whole   = r_accum[AW-1:FB];
    assign w_cov_hi  = {1'b1, {FB{1'b0}}} - {1'b0, w_frac};
    assign w_prod_hi = {{(FB+1){1'b0}}, i_stroke_alpha} * {{AB{1'b0}}, w_cov_hi};
    assign w_prod_lo = {{FB{1'b0}}, i_stroke_alpha} * {{AB{1'b0}}, w_frac};
    assign w_stop_ext = {r_stop_major[CB-1], r_stop_major};
    assign w_cur_inc  = r_cur_major + 1'b1;

    // Bresenham step decisions
    assign w_e2     = {r_err, 1'b0};
    assign w_maj_eq = r_cur_major[CB-1:0] == r_stop_major;
    assign w_min_eq = r_cur_minor == r_stop_minor;
    assign w_at_end = w_maj_eq & w_min_eq;
    assign w_c1     = w_e2 >= $signed({{2{r_nady[CB+1]}}, r_nady});
    assign w_c2     = w_e2 <= $signed({3'b000, r_adx});
    assign w_upd1   = !w_at_end & w_c1 & !w_maj_eq;
    assign w_upd2   = !w_at_end & !(w_c1 & w_maj_eq) & w_c2 & !w_min_eq;
    assign w_done   = w_at_end | (w_c1 & w_maj_eq) | (!(w_c1 & w_maj_eq) & w_c2 & w_min_eq);
    assign w_add1   = w_upd1 ? {r_nady[CB+1], r_nady} : '0;
    assign w_add2   = w_upd2 ? $signed({2'b00, r_adx}) : '0;

    // Next line state and slot contents
    always_comb begin
        n_busy       = r_busy;
        n_phase      = r_phase;
        n_steep      = r_steep;
        n_cur_major  = r_cur_major;
        n_stop_major = r_stop_major;
        n_cur_minor  = r_cur_minor;
        n_stop_minor = r_stop_minor;
        n_accum      = r_accum;
        n_slope      = r_slope;
        n_err        = r_err;
        n_adx        = r_adx;
        n_nady       = r_nady;
        n_signs      = r_signs;
        n_div_d      = r_div_d;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_ddy_neg    = r_ddy_neg;
        w_maj[0]     = r_cur_major[CB-1:0];
        w_min[0]     = r_cur_minor;
        w_alp[0]     = i_stroke_alpha;
        w_lst[0]     = 1'b0;
        w_maj[1]     = r_cur_major[CB-1:0];
        w_min[1]     = r_cur_minor + 1'b1;
        w_alp[1]     = '0;
        w_lst[1]     = 1'b0;

        if (i_cmd.load) begin
            n_busy = 1'b1;
            if (i_line_mode == MODE_ALIASED) begin
                n_phase      = PH_BRES;
                n_steep      = 1'b0;
                n_adx        = w_abs_ax;
                n_nady       = ~{1'b0, w_abs_ay} + 1'b1;
                n_signs      = {!(i_start_y < i_end_y), !(i_start_x < i_end_x)};
                n_err        = $signed({2'b00, w_abs_ax}) - $signed({2'b00, w_abs_ay});
                n_cur_major  = {i_start_x[CB-1], i_start_x};
                n_cur_minor  = i_start_y;
                n_stop_major = i_end_x;
                n_stop_minor = i_end_y;
            end else begin
                n_phase      = PH_WU_FIRST;
                n_steep      = w_st;
                n_cur_major  = {w_s0[CB-1], w_s0};
                n_cur_minor  = w_t0;
                n_stop_major = w_s1;
                n_stop_minor = w_t1;
                n_div_d      = w_wdx[CB-1:0];
                n_rem        = w_wdy_abs[CB-1:0];
                n_quo        = '0;
                n_ddy_neg    = w_wdy[CB];
            end
        end

        if (i_cmd.div_step) begin
            n_rem = w_dge ? w_dsub[CB-1:0] : w_dt[CB-1:0];
            n_quo = {r_quo[FB-1:0], w_dge};
        end

        if (i_cmd.div_fin) begin
            n_slope = w_slope;
            n_accum = {r_cur_minor, {FB{1'b0}}} + {{(CB-2){w_slope[FB+1]}}, w_slope};
        end

        if (i_cmd.adv && r_busy) begin
            unique case (r_phase)
                PH_WU_FIRST: begin
                    w_alp[0]    = i_stroke_alpha >> 1;
                    n_cur_major = w_cur_inc;
                    n_phase     = PH_WU_LAST;
                end
                PH_WU_LAST: begin
                    w_maj[0] = r_stop_major;
                    w_min[0] = r_stop_minor;
                    w_alp[0] = i_stroke_alpha >> 1;
                    w_maj[1] = r_stop_major;
                    w_min[1] = r_stop_minor + 1'b1;
                    w_lst[1] = !(r_cur_major < w_stop_ext);
                    if (!(r_cur_major < w_stop_ext)) begin
                        n_busy = 1'b0;
                    end else begin
                        n_phase = PH_WU_MID;
                    end
                end
                PH_WU_MID: begin
                    w_min[0]    = w_whole;
                    w_alp[0]    = w_prod_hi[AB+FB-1:FB];
                    w_min[1]    = w_whole + 1'b1;
                    w_alp[1]    = w_prod_lo[AB+FB-1:FB];
                    w_lst[1]    = !(w_cur_inc < w_stop_ext);
                    n_cur_major = w_cur_inc;
                    n_accum     = r_accum + {{(CB-2){r_slope[FB+1]}}, r_slope};
                    if (!(w_cur_inc < w_stop_ext)) begin
                        n_busy = 1'b0;
                    end
                end
                PH_BRES: begin
                    w_lst[0] = w_done;
                    n_err    = r_err + w_add1 + w_add2;
                    if (w_upd1) begin
                        n_cur_major = r_cur_major + (r_signs[0] ? '1 : (CB+1)'(1));
                    end
                    if (w_upd2) begin
                        n_cur_minor = r_cur_minor + (r_signs[1] ? '1 : CB'(1));
                    end
                    if (w_done) begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    // Swap back to screen axes for steep Wu lines
    assign w_map_steep = r_steep;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_WU_FIRST;
            r_steep <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_steep <= n_steep;
        end
    end

    // Line payload
    always_ff @(posedge i_clk) begin
        r_cur_major  <= n_cur_major;
        r_stop_major <= n_stop_major;
        r_cur_minor  <= n_cur_minor;
        r_stop_minor <= n_stop_minor;
        r_accum      <= n_accum;
        r_slope      <= n_slope;
        r_err        <= n_err;
        r_adx        <= n_adx;
        r_nady       <= n_nady;
        r_signs      <= n_signs;
        r_div_d      <= n_div_d;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_ddy_neg    <= n_ddy_neg;
    end

    // Capture result words on an advance
    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            for (int k = 0; k < 2; k++) begin
                r_px[k] <= w_map_steep ? w_min[k] : w_maj[k];
                r_py[k] <= w_map_steep ? w_maj[k] : w_min[k];
                r_pa[k] <= w_alp[k];
                r_pl[k] <= w_lst[k];
            end
        end
    end

endmodule

// ===== rtl/line_rasterizer.sv =====
// Line rasterizer top level: register port, controller and datapath.
//
// A start word loads two endpoints and produces no output; an advance word
// produces the next pixel word(s) of the line, the final one flagged by
// last_pixel. In aliased mode each advance gives one pixel, so with the
// output taken at once a new advance is accepted every cycle. In
// antialiased mode a start keeps the input stalled through the accept, the
// FRAC_BITS + 1 iterations of the bit-serial gradient divider and the step
// that forms the slope; each advance then gives two words through the
// two-entry result register. The next input word is accepted in the cycle
// the last pending result word is taken. Mode is latched at start;
// stroke_alpha is sampled at each advance.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB-style register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    // Input words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    // Output words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [ALPHA_BITS-1:0]        o_pixel_alpha,
    output logic                         o_last_pixel
);

    logic                  r_line_mode;
    logic [ALPHA_BITS-1:0] r_stroke_alpha;
    logic                  w_cfg_wr;
    t_cmd                  w_cmd;
    t_sts                  w_sts;

    // Register writes complete in the access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode    <= MODE_WU;
            r_stroke_alpha <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_LINE_MODE:    r_line_mode    <= pwdata[0];
                REG_STROKE_ALPHA: r_stroke_alpha <= pwdata[ALPHA_BITS-1:0];
                default:          r_line_mode    <= r_line_mode;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[2])
            REG_LINE_MODE:    prdata = {{(APB_DATA_BITS-1){1'b0}}, r_line_mode};
            REG_STROKE_ALPHA: prdata = {{(APB_DATA_BITS-ALPHA_BITS){1'b0}}, r_stroke_alpha};
            default:          prdata = '0;
        endcase
    end

    lr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_line_mode (r_line_mode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_line_mode    (r_line_mode),
        .i_stroke_alpha (r_stroke_alpha),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .o_sts          (w_sts),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_alpha  (o_pixel_alpha),
        .o_last_pixel   (o_last_pixel)
    );

endmodule
